@@ rtl/b64enc_pkg.sv @@
`default_nettype none

package b64enc_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned MAX_CHARS   = 4;
    localparam int unsigned IDX_W       = 2;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } b64enc_phase_t;

    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [IDX_W-1:0]                 last_idx;
        logic                             fin;
    } b64enc_cmd_t;

    function automatic logic [CHAR_W-1:0] b64enc_char(input logic [5:0] v);
        logic [CHAR_W-1:0] wide;
        wide = {1'b0, v};
        if (v < 6'd26)
        begin
            b64enc_char = wide + 7'h41;
        end
        else if (v < 6'd52)
        begin
            b64enc_char = wide + 7'd71;
        end
        else if (v < 6'd62)
        begin
            b64enc_char = wide - 7'd4;
        end
        else if (v == 6'd62)
        begin
            b64enc_char = 7'h2B;
        end
        else
        begin
            b64enc_char = 7'h2F;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/b64enc_front.sv @@
`default_nettype none

module b64enc_front
    import b64enc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,
    input  wire logic        queue_full,
    output logic             in_ready,
    output logic             push,
    output b64enc_cmd_t      cmd
);

    b64enc_phase_t phase_reg;
    b64enc_phase_t phase_next;
    logic [3:0]    leftover_reg;
    logic [3:0]    leftover_next;
    logic          accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;
    assign push     = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_FIRST;
            leftover_reg <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            leftover_reg <= leftover_next;
        end
    end

    always_comb
    begin
        phase_next    = PH_FIRST;
        leftover_next = 4'd0;
        if (!final_byte)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    phase_next    = PH_SECOND;
                    leftover_next = {2'b00, data_byte[1:0]};
                end
                PH_SECOND:
                begin
                    phase_next    = PH_THIRD;
                    leftover_next = data_byte[3:0];
                end
                default:
                begin
                    phase_next    = PH_FIRST;
                    leftover_next = 4'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.chars    = {MAX_CHARS{PAD_CHAR}};
        cmd.last_idx = 2'd0;
        cmd.fin      = final_byte;
        case (phase_reg)
            PH_FIRST:
            begin
                cmd.chars[0] = b64enc_char(data_byte[7:2]);
                cmd.chars[1] = b64enc_char({data_byte[1:0], 4'b0000});
                cmd.last_idx = final_byte ? 2'd3 : 2'd0;
            end
            PH_SECOND:
            begin
                cmd.chars[0] = b64enc_char({leftover_reg[1:0], data_byte[7:4]});
                cmd.chars[1] = b64enc_char({data_byte[3:0], 2'b00});
                cmd.last_idx = final_byte ? 2'd2 : 2'd0;
            end
            default:
            begin
                cmd.chars[0] = b64enc_char({leftover_reg, data_byte[7:6]});
                cmd.chars[1] = b64enc_char(data_byte[5:0]);
                cmd.last_idx = 2'd1;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/b64enc_queue.sv @@
`default_nettype none

module b64enc_queue
    import b64enc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire b64enc_cmd_t push_cmd,
    input  wire logic        pop,
    output logic             full,
    output logic             not_empty,
    output b64enc_cmd_t      head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    b64enc_cmd_t      entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/b64enc_back.sv @@
`default_nettype none

module b64enc_back
    import b64enc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               not_empty,
    input  wire b64enc_cmd_t        head,
    output logic                    pop,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic [CHAR_W-1:0]       code_char,
    output logic                    last_char
);

    logic [IDX_W-1:0]  idx_reg;
    logic              valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic              load;
    logic              at_end;

    assign load      = not_empty && (!valid_reg || out_ready);
    assign at_end    = (idx_reg == head.last_idx);
    assign pop       = load && at_end;
    assign out_valid = valid_reg;
    assign code_char = char_reg;
    assign last_char = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= at_end ? '0 : idx_reg + 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= head.chars[idx_reg];
            last_reg <= head.fin && at_end;
        end
    end

endmodule

`default_nettype wire

@@ rtl/base64_stream_encoder_core.sv @@
// The first character of a byte is written into a command queue entry, then loaded into the output register.
// One character per cycle leaves the output register, which sets the pace, while the queue holds a
// command and m_tready does not stall it; each byte yields one to four characters.
// Input requests are taken every cycle while the command queue has room.
// Reset clears the group phase, the leftover bits, the queue and the output valid flag.
`default_nettype none

module base64_stream_encoder_core
    import b64enc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [6:0] code_char, [7] zero
    output logic            m_tlast
);

    logic              push;
    logic              pop;
    logic              full;
    logic              not_empty;
    b64enc_cmd_t       cmd;
    b64enc_cmd_t       head;
    logic [CHAR_W-1:0] code_char;

    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .queue_full (full),
        .in_ready   (s_tready),
        .push       (push),
        .cmd        (cmd)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (cmd),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    b64enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .code_char (code_char),
        .last_char (m_tlast)
    );

    assign m_tdata = {1'b0, code_char};

endmodule

`default_nettype wire
